// ===== rtl/tdfc_pkg.sv =====
// ----------------------------------------------------------------------------
// tdfc_pkg
// Types and constants shared by the tensor element to FP32 converter.
// ----------------------------------------------------------------------------
package tdfc_pkg;

  typedef enum logic [2:0] {
    DT_F32  = 3'd0,
    DT_BF16 = 3'd1,
    DT_F16  = 3'd2,
    DT_E4M3 = 3'd3,
    DT_I64  = 3'd4
  } dtype_e;

  localparam logic [0:0] REG_ELEMENT_TYPE = 1'b0;
  localparam logic [0:0] REG_EXTREME_LIMIT = 1'b1;

  localparam logic [30:0] LIMIT_RESET = 31'h501502F9;
  localparam logic [30:0] FP32_INF_MAG = 31'h7F800000;
  localparam logic [31:0] FP32_QNAN = 32'h7FC00000;

  typedef struct packed {
    logic [63:0] raw_element;
    logic        last_in;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] fp32_bits;
    logic        nan_replaced;
    logic        extreme_replaced;
    logic        last_out;
  } out_beat_t;

  // Integer path state between the magnitude and rounding stages.
  typedef struct packed {
    logic        sign;
    logic        zero;
    logic [5:0]  msb;
    logic [63:0] norm;
  } int_norm_t;

endpackage

// ===== rtl/tdfc_int_to_fp.sv =====
// ----------------------------------------------------------------------------
// tdfc_int_to_fp
// Three-stage signed 64-bit integer to FP32 conversion, round to nearest even.
// ----------------------------------------------------------------------------
module tdfc_int_to_fp (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [63:0] value_i,
  output logic        valid_o,
  output logic [31:0] fp32_o
);
  import tdfc_pkg::*;

  logic        v1_q, v2_q, v3_q;
  logic        s1_q;
  logic [63:0] mag1_q;
  int_norm_t   n2_d, n2_q;
  logic [31:0] res3_d, res3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q   <= value_i[63];
    mag1_q <= value_i[63] ? (64'd0 - value_i) : value_i;
    n2_q   <= n2_d;
    res3_q <= res3_d;
  end

  // Leading one search and normalisation so that the top set bit lands at 63.
  always_comb begin
    n2_d.sign = s1_q;
    n2_d.zero = (mag1_q == 64'd0);
    n2_d.msb  = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (mag1_q[i]) n2_d.msb = 6'(i);
    end
    n2_d.norm = mag1_q << (6'd63 - n2_d.msb);
  end

  logic [24:0] mant;
  logic        guard, sticky, rnd;
  logic [7:0]  expo;

  always_comb begin
    guard  = n2_q.norm[39];
    sticky = |n2_q.norm[38:0];
    rnd    = guard && (sticky || n2_q.norm[40]);
    mant   = {1'b0, n2_q.norm[63:40]} + {24'd0, rnd};
    expo   = 8'd127 + {2'b00, n2_q.msb};
    if (mant[24]) begin
      expo = expo + 8'd1;
      mant = mant >> 1;
    end
    res3_d = n2_q.zero ? 32'd0 : {n2_q.sign, expo, mant[22:0]};
  end

  assign valid_o = v3_q;
  assign fp32_o  = res3_q;

endmodule

// ===== rtl/tensor_dtype_to_fp32_converter.sv =====
// ----------------------------------------------------------------------------
// tensor_dtype_to_fp32_converter
// Converts one raw tensor element per cycle to FP32 bits in a chosen type.
// ----------------------------------------------------------------------------
// Channel   Direction  Signals
// input     in         start_i, busy_o, in_i
// result    out        done_o, out_o
// config    in         cfg_we_i, cfg_idx_i, cfg_data_i
//
// Each beat passes through the r1, r2 and r3 registers from start to done; one beat may enter each cycle.
// The pipeline depth is set by the integer path: magnitude, leading-one shift, rounding.
// Reset clears the valid bits and loads the register reset values.
// busy_o is always low, and results cannot be held off.
module tensor_dtype_to_fp32_converter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  tdfc_pkg::in_beat_t  in_i,
  output logic                done_o,
  output tdfc_pkg::out_beat_t out_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [30:0]         cfg_data_i
);
  import tdfc_pkg::*;

  logic [2:0]  etype_q;
  logic [30:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      etype_q <= DT_F32;
      limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_ELEMENT_TYPE) etype_q <= cfg_data_i[2:0];
      else limit_q <= cfg_data_i;
    end
  end

  logic      acc;
  out_beat_t r1_d;
  out_beat_t r1_q, r2_q;
  logic      isint1_q, isint2_q;
  logic      iv;
  logic [31:0] ires;

  assign busy_o = 1'b0;
  assign acc    = start_i;

  logic [15:0] h;
  logic [7:0]  b;
  logic [31:0] w;
  logic [1:0]  p;

  always_comb begin
    h = in_i.raw_element[15:0];
    b = in_i.raw_element[7:0];
    w = {in_i.raw_element[15:0], 16'd0};
    p = b[2] ? 2'd2 : (b[1] ? 2'd1 : 2'd0);
    r1_d = '0;
    r1_d.last_out = in_i.last_in;
    unique case (etype_q)
      DT_F32: r1_d.fp32_bits = in_i.raw_element[31:0];
      DT_BF16: begin
        if (w[30:0] > FP32_INF_MAG) r1_d.nan_replaced = 1'b1;
        else if (w[30:0] == FP32_INF_MAG || w[30:0] > limit_q)
          r1_d.extreme_replaced = 1'b1;
        else r1_d.fp32_bits = w;
      end
      DT_F16: begin
        if (h[14:10] == 5'd0) r1_d.fp32_bits = {h[15], 31'd0};
        else if (h[14:10] == 5'd31) r1_d.fp32_bits = {h[15], 8'hFF, h[9:0], 13'd0};
        else r1_d.fp32_bits = {h[15], 8'({3'b000, h[14:10]} + 8'd112),
                               h[9:0], 13'd0};
      end
      DT_E4M3: begin
        if (b[6:3] == 4'd0) begin
          if (b[2:0] == 3'd0) r1_d.fp32_bits = {b[7], 31'd0};
          else r1_d.fp32_bits = {b[7], 8'd118 + {6'd0, p},
                                 23'({b[2:0] & ((3'd1 << p) - 3'd1)}) << (5'd23 - {3'd0, p})};
        end else if (b[6:0] == 7'h7F) r1_d.fp32_bits = FP32_QNAN | {b[7], 31'd0};
        else r1_d.fp32_bits = {b[7], 8'd120 + {4'd0, b[6:3]}, b[2:0], 20'd0};
      end
      default: r1_d.fp32_bits = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      isint1_q <= 1'b0;
      isint2_q <= 1'b0;
    end else begin
      isint1_q <= acc && (etype_q == DT_I64);
      isint2_q <= isint1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    r1_q <= r1_d;
    r2_q <= r1_q;
  end

  logic v1_q, v2_q, v3_q;
  out_beat_t r3_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= acc;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  logic isint3_q;
  always_ff @(posedge clk_i) begin
    r3_q     <= r2_q;
    isint3_q <= isint2_q;
  end

  tdfc_int_to_fp u_int (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (acc),
    .value_i (in_i.raw_element),
    .valid_o (iv),
    .fp32_o  (ires)
  );

  always_comb begin
    out_o = r3_q;
    if (isint3_q && iv) out_o.fp32_bits = ires;
  end
  assign done_o = v3_q;

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// Testbench for tensor_dtype_to_fp32_converter
// Streams raw elements of every element type through the converter, with
// random gaps between beats and register changes between phases. A scoreboard
// works out each expected FP32 pattern and flag set as beats are taken, and
// checks every result beat against them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import tdfc_pkg::*;

class conversion_scoreboard;
  logic [2:0]  elem_type;
  logic [30:0] limit_bits;
  out_beat_t   awaited[$];
  int          errors;

  function new();
    elem_type  = 3'(DT_F32);
    limit_bits = LIMIT_RESET;
    errors     = 0;
  endfunction

  static function logic [31:0] half_to_single(logic [15:0] h);
    logic [4:0] e;
    e = h[14:10];
    if (e == 5'd0) return {h[15], 31'd0};
    if (e == 5'h1F) return {h[15], 8'hFF, h[9:0], 13'd0};
    return {h[15], 8'(e + 8'd112), h[9:0], 13'd0};
  endfunction

  static function logic [31:0] fp8_to_single(logic [7:0] b);
    logic [3:0]  e;
    logic [2:0]  m;
    logic [22:0] frac;
    int          p;
    e = b[6:3];
    m = b[2:0];
    if (e == 4'd0) begin
      if (m == 3'd0) return {b[7], 31'd0};
      p = m[2] ? 2 : (m[1] ? 1 : 0);
      frac = 23'(m & 3'((1 << p) - 1)) << (23 - p);
      return {b[7], 8'(118 + p), frac};
    end
    if (e == 4'hF && m == 3'd7) return {b[7], 31'd0} | FP32_QNAN;
    return {b[7], 8'(e + 8'd120), m, 20'd0};
  endfunction

  static function logic [31:0] int_to_single(logic [63:0] raw);
    logic        neg;
    logic [63:0] mag, rem, half, mant;
    int          p, sh;
    neg = raw[63];
    mag = neg ? -raw : raw;
    if (mag == 64'd0) return 32'd0;
    p = 63;
    while (p > 0 && !mag[p]) p--;
    if (p <= 23) begin
      mant = mag << (23 - p);
    end else begin
      sh   = p - 23;
      rem  = mag & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      mant = mag >> sh;
      if (rem > half || (rem == half && mant[0])) mant++;
      if (mant == (64'd1 << 24)) begin
        mant = mant >> 1;
        p++;
      end
    end
    return {neg, 8'(127 + p), mant[22:0]};
  endfunction

  function void note_input(in_beat_t b);
    out_beat_t   r;
    logic [31:0] w;
    r = '0;
    r.last_out = b.last_in;
    case (elem_type)
      DT_F32: r.fp32_bits = b.raw_element[31:0];
      DT_BF16: begin
        w = {b.raw_element[15:0], 16'd0};
        if (w[30:0] > FP32_INF_MAG) r.nan_replaced = 1'b1;
        else if (w[30:0] == FP32_INF_MAG || w[30:0] > limit_bits) r.extreme_replaced = 1'b1;
        else r.fp32_bits = w;
      end
      DT_F16: r.fp32_bits = half_to_single(b.raw_element[15:0]);
      DT_E4M3: r.fp32_bits = fp8_to_single(b.raw_element[7:0]);
      DT_I64: r.fp32_bits = int_to_single(b.raw_element);
      default: r.fp32_bits = 32'd0;
    endcase
    awaited.push_back(r);
  endfunction

  function void check_result(out_beat_t got);
    out_beat_t want;
    if (awaited.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result beat %h", got);
      return;
    end
    want = awaited.pop_front();
    if (got.fp32_bits !== want.fp32_bits || got.nan_replaced !== want.nan_replaced ||
        got.extreme_replaced !== want.extreme_replaced || got.last_out !== want.last_out) begin
      errors++;
      if (errors <= 10)
        $display("type %0d: expected bits %h nan %b ext %b last %b, got %h %b %b %b",
                 elem_type, want.fp32_bits, want.nan_replaced, want.extreme_replaced,
                 want.last_out, got.fp32_bits, got.nan_replaced, got.extreme_replaced,
                 got.last_out);
    end
  endfunction
endclass

module tb;
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  in_beat_t    in_i = '0;
  logic        done_o;
  out_beat_t   out_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [30:0] cfg_data_i = '0;

  conversion_scoreboard sb = new();

  tensor_dtype_to_fp32_converter uut (.*);

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && start_i && !busy_o) sb.note_input(in_i);
    if (rst_ni && done_o) sb.check_result(out_o);
  end

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_element(logic [63:0] raw, logic last, bit gaps);
    int g;
    start_i <= 1'b1;
    in_i    <= '{raw_element: raw, last_in: last};
    @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
    @(posedge clk_i);
    g = gaps ? gap_length() : 0;
    if (g > 0) begin
      start_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.awaited.size() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [30:0] value);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_ELEMENT_TYPE) sb.elem_type = value[2:0];
    else sb.limit_bits = value;
  endtask

  function automatic logic [63:0] random_element(logic [2:0] t);
    logic [63:0] v;
    int          k;
    v = {$urandom, $urandom};
    k = $urandom_range(0, 9);
    if (t == 3'(DT_I64)) begin
      if (k < 3) v = v >> $urandom_range(0, 63);
      else if (k < 5) v = -(v >> $urandom_range(0, 63));
      else if (k < 7) v = (64'($urandom_range(1, 3)) << $urandom_range(0, 40)) << 23 |
                          (64'd1 << $urandom_range(0, 30));
    end else if (t == 3'(DT_BF16) && k < 4) begin
      v[14:7] = $urandom_range(0, 1) ? 8'hFF : 8'(8'd150 + $urandom_range(0, 20));
    end else if ((t == 3'(DT_F16) || t == 3'(DT_E4M3)) && k < 3) begin
      v[14:10] = k[0] ? 5'h1F : 5'h00;
      v[6:3]   = k[0] ? 4'hF : 4'h0;
    end
    return v;
  endfunction

  initial begin
    #5ms;
    $display("tensor_dtype_to_fp32_converter: mismatch");
    $finish;
  end

  initial begin
    logic [30:0] limits[4];
    logic [2:0]  t;
    logic [15:0] bf_set[6];
    logic [15:0] hf_set[4];
    logic [7:0]  e4_set[6];
    bf_set = '{16'h7FC1, 16'h7F80, 16'hFF80, 16'h5015, 16'h5016, 16'h8001};
    hf_set = '{16'h83FF, 16'h7C00, 16'hFE01, 16'h3C00};
    e4_set = '{8'h01, 8'h02, 8'h87, 8'h7F, 8'hFF, 8'h7E};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_element(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
    send_element(64'h0000_0000_3F80_0000, 1'b1, 1'b0);
    write_reg(REG_ELEMENT_TYPE, 31'(DT_BF16));
    foreach (bf_set[i])
      send_element(64'(bf_set[i]), 1'b0, 1'b0);
    write_reg(REG_ELEMENT_TYPE, 31'(DT_F16));
    foreach (hf_set[i])
      send_element(64'(hf_set[i]), 1'b0, 1'b0);
    write_reg(REG_ELEMENT_TYPE, 31'(DT_E4M3));
    foreach (e4_set[i])
      send_element(64'(e4_set[i]), 1'b0, 1'b0);
    write_reg(REG_ELEMENT_TYPE, 31'(DT_I64));
    send_element(64'd0, 1'b0, 1'b0);
    send_element(64'h8000_0000_0000_0000, 1'b0, 1'b0);
    send_element(64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
    send_element(64'd16777217, 1'b0, 1'b0);
    send_element(64'd16777219, 1'b1, 1'b0);
    write_reg(REG_ELEMENT_TYPE, 31'd7);
    send_element(64'hDEAD_BEEF_0123_4567, 1'b1, 1'b0);

    limits = '{31'd0, FP32_INF_MAG, LIMIT_RESET, 31'h3F80_0000};
    for (int ph = 0; ph < 24; ph++) begin
      t = (ph < 20) ? 3'(ph % 5) : 3'($urandom_range(5, 7));
      write_reg(REG_ELEMENT_TYPE, 31'(t));
      if (t == 3'(DT_BF16))
        write_reg(REG_EXTREME_LIMIT, (ph < 16) ? limits[ph / 5] :
                  31'($urandom_range(0, 32'h7F80_0000)));
      for (int n = 0; n < ((ph < 20) ? 80 : 25); n++)
        send_element(random_element(t), 1'($urandom_range(0, 7) == 0), ph % 3 != 2);
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tensor_dtype_to_fp32_converter: match");
    end else begin
      $display("tensor_dtype_to_fp32_converter: mismatch");
    end
    $finish;
  end
endmodule
